>>> rtl/core/twra_pkg.sv
`timescale 1ns / 1ps

// Shared types and codes for the time window range alarm
package twra_pkg;

   // Fixed field widths
   localparam int ROW_W     = 10;
   localparam int DATA_W    = 32;
   localparam int WIN_W     = 31;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 2;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_WIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_WIN    = 2'd3;

   // Scan pointer operations
   localparam logic [2:0] PTR_HOLD     = 3'd0;
   localparam logic [2:0] PTR_LOAD     = 3'd1;
   localparam logic [2:0] PTR_DEC      = 3'd2;
   localparam logic [2:0] PTR_INC      = 3'd3;
   localparam logic [2:0] PTR_NEXT_ROW = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic       clear;
      logic       append;
      logic       rd;
      logic       set_bounds;
      logic [2:0] ptr_op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bad_index;
      logic alarm;
      logic below_lo;
      logic above_hi;
      logic ptr_zero;
      logic ptr_last;
      logic row_last;
      logic back_on;
      logic fwd_on;
   } dp_stat_type;

endpackage

>>> rtl/core/twra_datapath.sv
`timescale 1ns / 1ps

// Sample store, row count, settings, scan pointer and compare logic
module twra_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  twra_pkg::dp_cmd_type                  cmd,
   output twra_pkg::dp_stat_type                 stat,
   input  logic signed [twra_pkg::DATA_W-1:0]    req_sample_in,
   input  logic signed [twra_pkg::DATA_W-1:0]    req_time_in,
   input  logic        [twra_pkg::ROW_W-1:0]     req_row_index,
   input  logic                                  csr_wr,
   input  logic        [twra_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [twra_pkg::DATA_W-1:0]    csr_wdata
);
   import twra_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int NW = CW + 1;
   localparam int XW = (CW > ROW_W) ? CW : ROW_W;
   localparam int MW = 2 * DATA_W;

   // Settings
   logic signed [DATA_W-1:0] range_low_ff, range_high_ff;
   logic        [WIN_W-1:0]  back_win_ff, fwd_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '0;
         back_win_ff   <= '0;
         fwd_win_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            CSR_BACK_WIN:   back_win_ff   <= csr_wdata[WIN_W-1:0];
            CSR_FWD_WIN:    fwd_win_ff    <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Row count
   logic [CW-1:0] count_ff, count_in;
   logic          full;

   assign full = (count_ff >= CW'(DEPTH));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear)
         count_in = '0;
      else if (cmd.append && !full)
         count_in = count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

   // Scan pointer and queried row
   logic [XW-1:0] row_x;
   logic [IW-1:0] ptr_ff, ptr_in, row_ff, row_in;

   assign row_x = XW'(req_row_index);

   always_comb begin
      ptr_in = ptr_ff;
      row_in = row_ff;
      case (cmd.ptr_op)
         PTR_LOAD: begin
            ptr_in = row_x[IW-1:0];
            row_in = row_x[IW-1:0];
         end
         PTR_DEC:      ptr_in = ptr_ff - IW'(1);
         PTR_INC:      ptr_in = ptr_ff + IW'(1);
         PTR_NEXT_ROW: ptr_in = row_ff + IW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      row_ff <= row_in;
   end

   // Store: value in the upper half, time in the lower half
   logic [MW-1:0] mem_ff [DEPTH];
   logic [MW-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.append && !full)
         mem_ff[count_ff[IW-1:0]] <= {req_sample_in, req_time_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.rd)
         rd_q_ff <= mem_ff[ptr_ff];
   end

   // Window bounds, taken from the queried row's time
   logic signed [DATA_W-1:0] rd_val, rd_time;
   logic signed [DATA_W:0]   rd_time_x, lo_ff, hi_ff, lo_in, hi_in;

   assign rd_val    = rd_q_ff[MW-1:DATA_W];
   assign rd_time   = rd_q_ff[DATA_W-1:0];
   assign rd_time_x = {rd_time[DATA_W-1], rd_time};
   assign lo_in     = rd_time_x - $signed({2'b00, back_win_ff});
   assign hi_in     = rd_time_x + $signed({2'b00, fwd_win_ff});

   always_ff @(posedge clock) begin
      if (cmd.set_bounds) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // Status
   logic [NW-1:0] ptr_nx, row_nx, count_x;
   logic [XW-1:0] count_w;

   assign ptr_nx  = NW'(ptr_ff) + NW'(1);
   assign row_nx  = NW'(row_ff) + NW'(1);
   assign count_x = NW'(count_ff);
   assign count_w = XW'(count_ff);

   always_comb begin
      stat.bad_index = (row_x >= count_w);
      stat.alarm     = (rd_val < range_low_ff) || (rd_val > range_high_ff);
      stat.below_lo  = (rd_time_x < lo_ff);
      stat.above_hi  = (rd_time_x > hi_ff);
      stat.ptr_zero  = (ptr_ff == '0);
      stat.ptr_last  = (ptr_nx >= count_x);
      stat.row_last  = (row_nx >= count_x);
      stat.back_on   = (back_win_ff != '0);
      stat.fwd_on    = (fwd_win_ff != '0);
   end

endmodule

>>> rtl/core/twra_ctrl.sv
`timescale 1ns / 1ps

// Command sequencer: runs the row check and the backward and forward scans
module twra_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [twra_pkg::CMD_W-1:0]    req_cmd,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_bad_index,
   output twra_pkg::dp_cmd_type          cmd,
   input  twra_pkg::dp_stat_type         stat
);
   import twra_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ROW_RD = 3'd1;
   localparam logic [2:0] S_ROW_EV = 3'd2;
   localparam logic [2:0] S_BK_RD  = 3'd3;
   localparam logic [2:0] S_BK_EV  = 3'd4;
   localparam logic [2:0] S_FW_RD  = 3'd5;
   localparam logic [2:0] S_FW_EV  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_hit_ff, rsp_hit_in;
   logic       rsp_bad_ff, rsp_bad_in;
   logic       fwd_go;

   // Forward scan is worth starting only with a window and a later row
   assign fwd_go = stat.fwd_on && !stat.row_last;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_bad_in     = rsp_bad_ff;
      cmd.clear      = 1'b0;
      cmd.append     = 1'b0;
      cmd.rd         = 1'b0;
      cmd.set_bounds = 1'b0;
      cmd.ptr_op     = PTR_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_CLEAR:  cmd.clear  = 1'b1;
                  CMD_APPEND: cmd.append = 1'b1;
                  CMD_QUERY: begin
                     if (stat.bad_index) begin
                        rsp_valid_in = 1'b1;
                        rsp_hit_in   = 1'b0;
                        rsp_bad_in   = 1'b1;
                     end else begin
                        cmd.ptr_op = PTR_LOAD;
                        state_in   = S_ROW_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_ROW_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_ROW_EV;
         end

         // Queried row itself
         S_ROW_EV: begin
            cmd.set_bounds = 1'b1;
            rsp_bad_in     = 1'b0;
            if (stat.alarm) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               state_in     = S_IDLE;
            end else if (stat.back_on && !stat.ptr_zero) begin
               cmd.ptr_op = PTR_DEC;
               state_in   = S_BK_RD;
            end else if (fwd_go) begin
               cmd.ptr_op = PTR_NEXT_ROW;
               state_in   = S_FW_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end

         S_BK_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_BK_EV;
         end

         // Earlier rows, nearest first
         S_BK_EV: begin
            if (!stat.below_lo && stat.alarm) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               state_in     = S_IDLE;
            end else if (!stat.below_lo && !stat.ptr_zero) begin
               cmd.ptr_op = PTR_DEC;
               state_in   = S_BK_RD;
            end else if (fwd_go) begin
               cmd.ptr_op = PTR_NEXT_ROW;
               state_in   = S_FW_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end

         S_FW_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_FW_EV;
         end

         // Later rows
         S_FW_EV: begin
            if (!stat.above_hi && stat.alarm) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               state_in     = S_IDLE;
            end else if (!stat.above_hi && !stat.ptr_last) begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_FW_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

>>> rtl/core/time_window_range_alarm_unit.sv
`timescale 1ns / 1ps

// Time window range alarm. Clear and append are taken without raising busy
// and give no response. A query gives one response, shown for a single cycle
// with rsp_valid high; there is no way to hold it off, so it must be captured
// in that cycle. A query on an index at or beyond the row count answers on the
// next cycle. Otherwise each row examined takes a read on the single read port
// of the sample store and then a compare: the queried row, then earlier rows
// back to the window edge, then later rows up to the forward edge. busy stays
// high while the rows are scanned. Settings may be written whenever busy is
// low and no response is pending.
module time_window_range_alarm_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic        [twra_pkg::CMD_W-1:0]     req_cmd,
   input  logic signed [twra_pkg::DATA_W-1:0]    req_sample_in,
   input  logic signed [twra_pkg::DATA_W-1:0]    req_time_in,
   input  logic        [twra_pkg::ROW_W-1:0]     req_row_index,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_bad_index,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [twra_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [twra_pkg::DATA_W-1:0]    csr_wdata
);
   import twra_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        csr_wr;

   // Settings transfers are always accepted
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   twra_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_bad_index (rsp_bad_index),
      .cmd           (dp_cmd),
      .stat          (dp_stat)
   );

   twra_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .stat          (dp_stat),
      .req_sample_in (req_sample_in),
      .req_time_in   (req_time_in),
      .req_row_index (req_row_index),
      .csr_wr        (csr_wr),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

endmodule

>>> bench/time_window_range_alarm_unit_tb.sv
`timescale 1ns / 1ps

module time_window_range_alarm_unit_tb;
   import twra_pkg::*;

   // Small store so that the full-store phase fits the item budget
   localparam int DEPTH = 128;
   localparam int ITEM_TARGET = 580;
   // Command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // One unit in Q16.16
   localparam int UNIT = 32'h0001_0000;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic hit;
      logic bad_index;
   } alarm_rsp_type;

   // Own copy of the sample store and settings; predicts each query answer
   class alarm_scoreboard;
      longint value_mem [DEPTH];
      longint time_mem [DEPTH];
      int unsigned row_count;
      longint low_bound, high_bound, back_span, fwd_span;
      alarm_rsp_type pending_q [$];
      int unsigned errors;

      function new();
         row_count = 0;
         low_bound = 0;
         high_bound = 0;
         back_span = 0;
         fwd_span = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_RANGE_LOW:  low_bound = longint'(signed'(data));
            CSR_RANGE_HIGH: high_bound = longint'(signed'(data));
            CSR_BACK_WIN:   back_span = longint'(data[WIN_W-1:0]);
            CSR_FWD_WIN:    fwd_span = longint'(data[WIN_W-1:0]);
            default: ;
         endcase
      endfunction

      function bit out_of_range(int r);
         return value_mem[r] < low_bound || value_mem[r] > high_bound;
      endfunction

      // Row itself, then earlier rows back to the window edge, then later rows
      function bit window_alarm(int r);
         longint lo_limit, hi_limit;
         int j;
         if (out_of_range(r)) return 1'b1;
         if (back_span != 0) begin
            lo_limit = time_mem[r] - back_span;
            for (j = r - 1; j >= 0; j--) begin
               if (time_mem[j] < lo_limit) break;
               if (out_of_range(j)) return 1'b1;
            end
         end
         if (fwd_span != 0) begin
            hi_limit = time_mem[r] + fwd_span;
            for (j = r + 1; j < int'(row_count); j++) begin
               if (time_mem[j] > hi_limit) break;
               if (out_of_range(j)) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] sample,
                                 logic signed [DATA_W-1:0] tstamp, logic [ROW_W-1:0] row);
         alarm_rsp_type rsp;
         case (cmd)
            CMD_CLEAR: row_count = 0;
            CMD_APPEND: begin
               // a full store drops the sample
               if (row_count < DEPTH) begin
                  value_mem[row_count] = longint'(sample);
                  time_mem[row_count] = longint'(tstamp);
                  row_count++;
               end
            end
            CMD_QUERY: begin
               if (row >= row_count) begin
                  rsp.hit = 1'b0;
                  rsp.bad_index = 1'b1;
               end else begin
                  rsp.hit = window_alarm(int'(row));
                  rsp.bad_index = 1'b0;
               end
               pending_q.push_back(rsp);
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic hit, logic bad_index);
         alarm_rsp_type want;
         if (pending_q.size() == 0) begin
            $error("response with none outstanding: hit %b bad_index %b", hit, bad_index);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (hit !== want.hit) begin
            $error("hit: expected %b, got %b", want.hit, hit);
            errors++;
         end
         if (bad_index !== want.bad_index) begin
            $error("bad_index: expected %b, got %b", want.bad_index, bad_index);
            errors++;
         end
      endfunction

      function bit drained();
         return pending_q.size() == 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = CMD_CLEAR;
   logic signed [DATA_W-1:0] req_sample_in = '0;
   logic signed [DATA_W-1:0] req_time_in = '0;
   logic [ROW_W-1:0] req_row_index = '0;
   logic rsp_valid, rsp_hit, rsp_bad_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RANGE_LOW;
   logic [DATA_W-1:0] csr_wdata = '0;

   alarm_scoreboard board = new();
   int unsigned items_sent = 0;
   bit no_gap = 1'b0;
   int band = UNIT;

   time_window_range_alarm_unit #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_sample_in(req_sample_in),
      .req_time_in(req_time_in),
      .req_row_index(req_row_index),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit),
      .rsp_bad_index(rsp_bad_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Responses cannot be held off: capture every strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         board.check_response(rsp_hit, rsp_bad_index);
      end
   end

   // One command transfer; start stays high when the next one follows at once
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] sample,
                            input logic [DATA_W-1:0] tstamp, input logic [ROW_W-1:0] row);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_sample_in <= sample;
      req_time_in <= tstamp;
      req_row_index <= row;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(cmd, sample, tstamp, row);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Register transfer; csr_valid is left high for the caller to drop
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_reg(idx, data);
   endtask

   task automatic write_regs(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                             input logic [DATA_W-1:0] bw, input logic [DATA_W-1:0] fw);
      write_reg(CSR_RANGE_LOW, lo);
      write_reg(CSR_RANGE_HIGH, hi);
      write_reg(CSR_BACK_WIN, bw);
      write_reg(CSR_FWD_WIN, fw);
      csr_valid <= 1'b0;
   endtask

   // Wait for all answers and for the last no-response command to finish
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (!board.drained() || busy !== 1'b0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_window();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2: return S32_MAX;
         3: return $urandom;   // top bit falls outside the 31-bit register
         default: return $urandom_range(1, 8 * UNIT);
      endcase
   endfunction

   task automatic random_settings();
      logic [DATA_W-1:0] lo, hi;
      band = $urandom_range(1, 200) * UNIT + $urandom_range(0, UNIT - 1);
      case ($urandom_range(0, 5))
         0: begin
            lo = S32_MIN;
            hi = S32_MAX;
         end
         1: begin
            // inverted bounds: every row alarmed
            lo = S32_MAX;
            hi = S32_MIN;
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = -band;
            hi = band;
         end
      endcase
      write_regs(lo, hi, pick_window(), pick_window());
   endtask

   initial begin
      int rows, queries, k;
      logic [DATA_W-1:0] sample, tstamp;
      logic [ROW_W-1:0] row;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, empty store, field extremes, unused command
      send_item(CMD_QUERY, '0, '0, '0);
      send_item(CMD_UNUSED, $urandom, $urandom, ROW_W'($urandom));
      send_item(CMD_APPEND, '0, '0, '0);
      send_item(CMD_QUERY, '0, '0, '0);
      send_item(CMD_APPEND, S32_MIN, S32_MAX, '1);
      send_item(CMD_APPEND, S32_MAX, S32_MIN, '0);
      send_item(CMD_QUERY, '0, '0, 10'd1);
      send_item(CMD_QUERY, '0, '0, '1);

      // Directed: window edges, equal times count as inside
      settle();
      write_regs(-10 * UNIT, 10 * UNIT, 2 * UNIT, 2 * UNIT);
      send_item(CMD_CLEAR, '1, '1, '1);
      send_item(CMD_APPEND, '0, 0 * UNIT, '0);
      send_item(CMD_APPEND, '0, 1 * UNIT, '0);
      send_item(CMD_APPEND, 11 * UNIT, 2 * UNIT, '0);
      send_item(CMD_APPEND, -10 * UNIT, 3 * UNIT, '0);
      send_item(CMD_APPEND, 10 * UNIT, 6 * UNIT, '0);
      send_item(CMD_QUERY, '0, '0, 10'd0);
      send_item(CMD_QUERY, '0, '0, 10'd4);
      send_item(CMD_QUERY, '0, '0, 10'd2);
      settle();
      write_regs(S32_MAX, S32_MIN, S32_MAX, '0);
      send_item(CMD_QUERY, '0, '0, 10'd4);
      settle();
      write_regs(S32_MIN, S32_MAX, S32_MAX, S32_MAX);
      send_item(CMD_QUERY, '0, '0, 10'd3);

      // Random phases: fresh settings, a short run of samples, then queries;
      // room is left for the full-store phase
      while (items_sent + DEPTH + 8 < ITEM_TARGET) begin
         settle();
         random_settings();
         no_gap = ($urandom_range(0, 3) == 0);
         send_item(CMD_CLEAR, $urandom, $urandom, ROW_W'($urandom));
         rows = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 40);
         tstamp = $urandom;
         for (k = 0; k < rows; k++) begin
            if ($urandom_range(0, 6) == 0) begin
               case ($urandom_range(0, 2))
                  0: sample = band + 1;
                  1: sample = -band - 1;
                  default: sample = $urandom;
               endcase
            end else begin
               sample = $urandom_range(0, 2 * band) - band;
            end
            // mostly rising times, now and then a wild jump
            if ($urandom_range(0, 9) == 0) tstamp = $urandom;
            else tstamp = tstamp + $urandom_range(0, 3 * UNIT);
            send_item(CMD_APPEND, sample, tstamp, ROW_W'($urandom));
         end
         queries = $urandom_range(3, 12);
         for (k = 0; k < queries; k++) begin
            case ($urandom_range(0, 9))
               7: row = ROW_W'(board.row_count + $urandom_range(0, 3));
               8: row = ROW_W'($urandom);
               9: begin
                  // noise between queries
                  case ($urandom_range(0, 2))
                     0: send_item(CMD_UNUSED, $urandom, $urandom, ROW_W'($urandom));
                     1: send_item(CMD_APPEND, $urandom_range(0, 2 * band) - band,
                                  tstamp + $urandom_range(0, UNIT), ROW_W'($urandom));
                     default: send_item(CMD_CLEAR, $urandom, $urandom, ROW_W'($urandom));
                  endcase
                  row = ROW_W'($urandom);
               end
               default: begin
                  if (board.row_count > 0)
                     row = ROW_W'($urandom_range(0, board.row_count - 1));
                  else row = ROW_W'($urandom);
               end
            endcase
            send_item(CMD_QUERY, $urandom, $urandom, row);
         end
      end

      // Full store: appends past the end are dropped, whole-store scans
      settle();
      write_regs(-UNIT, UNIT, S32_MAX, S32_MAX);
      no_gap = 1'b1;
      send_item(CMD_CLEAR, '0, '0, '0);
      tstamp = $urandom;
      for (k = 0; k < DEPTH - 1; k++) begin
         send_item(CMD_APPEND, $urandom_range(0, 2 * UNIT) - UNIT, tstamp, ROW_W'($urandom));
      end
      send_item(CMD_APPEND, 2 * UNIT, tstamp, ROW_W'($urandom));
      send_item(CMD_APPEND, 5 * UNIT, tstamp, ROW_W'($urandom));
      send_item(CMD_APPEND, -5 * UNIT, tstamp, ROW_W'($urandom));
      no_gap = 1'b0;
      send_item(CMD_QUERY, '0, '0, 10'd0);
      send_item(CMD_QUERY, '0, '0, ROW_W'(DEPTH - 1));
      send_item(CMD_QUERY, '0, '0, ROW_W'(DEPTH / 2));
      settle();
      write_regs(-UNIT, UNIT, '0, '0);
      send_item(CMD_QUERY, '0, '0, ROW_W'(DEPTH / 2));
      send_item(CMD_QUERY, '0, '0, ROW_W'(DEPTH - 1));

      settle();
      if (board.errors == 0) begin
         $display("time_window_range_alarm_unit regression: pass");
      end else begin
         $display("time_window_range_alarm_unit regression: fail");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("time_window_range_alarm_unit regression: fail");
      $finish;
   end

endmodule
